// ----- hw/rtl/edf_pkg.sv -----
// edf_pkg: shared constants, types and helpers for the edf tick scheduler
// no dependencies; used by the slot cell, the top level and the bench
`default_nettype none
package edf_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam logic [31:0] SLOT_COUNT_V = SLOT_COUNT;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ADD,
    OP_REL,
    OP_DROP,
    OP_SEARCH,
    OP_RUN
  } cell_op_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    cell_op_t           op;
    logic [SLOT_W-1:0]  sel;
    logic [31:0]        cur_time;
    logic [15:0]        period;
    logic [15:0]        rel_dl;
    logic [15:0]        cap;
  } cell_ctrl_t;

  // search token passed down the chain
  typedef struct packed {
    logic               found;
    logic [31:0]        key;
    logic [SLOT_W-1:0]  idx;
  } token_t;

  // a at or after b, modulo 2^32
  function automatic logic reached(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return ~d[31];
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/edf_if.sv -----
// edf_in_if / edf_out_if: valid-ready channels for task and tick transactions
// depends on nothing
`default_nettype none
interface edf_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] task_period;
  logic [15:0] task_deadline;
  logic [15:0] task_capacity;
  modport source (output valid, action, task_period, task_deadline, task_capacity,
                  input ready);
  modport sink   (input valid, action, task_period, task_deadline, task_capacity,
                  output ready);
endinterface

interface edf_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] running_slot;
  logic       job_finished;
  logic       deadline_missed;
  logic       table_full;
  modport source (output valid, running_slot, job_finished, deadline_missed, table_full,
                  input ready);
  modport sink   (input valid, running_slot, job_finished, deadline_missed, table_full,
                  output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/edf_tick_scheduler_unit.sv -----
// edf_tick_scheduler_unit: top level of the periodic edf scheduler
// depends on edf_pkg, edf_in_if / edf_out_if and edf_cell
`default_nettype none
// usage
//   in_ch carries one transaction per item: action 1 adds a periodic task
//   (period, relative deadline, capacity) to the lowest free slot, action 0
//   advances the scheduler by one tick. out_ch returns exactly one result
//   transaction per input transaction, in order.
//   a tick result gives the slot that ran (SLOT_COUNT when idle), whether its
//   job finished and whether any job was dropped at its deadline; an add
//   result flags table_full when no slot was free.
// sequence
//   an add passes through the add state to the done state (straight to
//   the done state when the table is full); a tick runs one release pass,
//   one drop pass, SLOT_COUNT steps of the deadline search that walks down
//   the cell chain, one run update, one step to collect the finish flag
//   and one to load the output register.
//   one item is in work at a time; the next is taken once the current
//   result has moved into the output register.
// reset
//   synchronous active-low reset frees all slots and clears time to zero.
// stall
//   a held result stays in the output register; the next item is still
//   accepted and processed, then waits until the register frees up.
module edf_tick_scheduler_unit
  import edf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  edf_in_if.sink    in_ch,
  edf_out_if.source out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_REL,
    S_DROP,
    S_SEARCH,
    S_RUN,
    S_FIN,
    S_DONE
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [31:0]       time_r;
  logic [15:0]       period_r, rel_dl_r, cap_r;
  logic [SLOT_W-1:0] sel_r;
  logic [3:0]        res_run_r;
  logic              res_fin_r, res_miss_r, res_full_r;

  logic              out_valid_r;
  logic [3:0]        out_run_r;
  logic              out_fin_r, out_miss_r, out_full_r;

  cell_ctrl_t        ctrl;
  token_t            tok [SLOT_COUNT+1];
  logic [SLOT_COUNT-1:0] used_v, drop_v, fin_v;

  // lowest free slot
  logic              free_any;
  logic [SLOT_W-1:0] free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!used_v[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  // winner index widened to 32 bits; the 4-bit result field takes its low bits
  logic [31:0] win32;
  assign win32 = {{(32-SLOT_W){1'b0}}, tok[SLOT_COUNT].idx};

  // broadcast to the cell row
  always_comb begin
    ctrl.sel      = sel_r;
    ctrl.cur_time = time_r;
    ctrl.period   = period_r;
    ctrl.rel_dl   = rel_dl_r;
    ctrl.cap      = cap_r;
    unique case (state_r)
      S_ADD:    ctrl.op = OP_ADD;
      S_REL:    ctrl.op = OP_REL;
      S_DROP:   ctrl.op = OP_DROP;
      S_SEARCH: ctrl.op = OP_SEARCH;
      S_RUN:    ctrl.op = tok[SLOT_COUNT].found ? OP_RUN : OP_NONE;
      default:  ctrl.op = OP_NONE;
    endcase
    if (state_r == S_RUN) begin
      ctrl.sel = tok[SLOT_COUNT].idx;
    end
  end

  assign tok[0] = '{found: 1'b0, key: '0, idx: '0};

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    edf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .slot_id  (SLOT_W'(g)),
      .ctrl     (ctrl),
      .tok_in   (tok[g]),
      .tok_out  (tok[g+1]),
      .used     (used_v[g]),
      .dropped  (drop_v[g]),
      .finished (fin_v[g])
    );
  end

  assign in_ch.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // the done state reloads the register itself
      if (out_valid_r && out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            period_r   <= in_ch.task_period;
            rel_dl_r   <= in_ch.task_deadline;
            cap_r      <= in_ch.task_capacity;
            sel_r      <= free_idx;
            res_run_r  <= SLOT_COUNT_V[3:0];
            res_fin_r  <= 1'b0;
            res_miss_r <= 1'b0;
            res_full_r <= 1'b0;
            if (!in_ch.action) begin
              state_r <= S_REL;
            end else if (free_any) begin
              state_r <= S_ADD;
            end else begin
              res_full_r <= 1'b1;
              state_r    <= S_DONE;
            end
          end
        end
        S_ADD:  state_r <= S_DONE;
        S_REL:  state_r <= S_DROP;
        S_DROP: begin
          cnt_r   <= '0;
          state_r <= S_SEARCH;
        end
        S_SEARCH: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(SLOT_COUNT - 1)) begin
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          res_miss_r <= |drop_v;
          if (tok[SLOT_COUNT].found) begin
            res_run_r <= win32[3:0];
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          // only the winning cell can raise its finish flag
          res_fin_r <= (res_run_r != SLOT_COUNT_V[3:0]) && (|fin_v);
          time_r    <= time_r + 32'd1;
          state_r   <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_run_r   <= res_run_r;
            out_fin_r   <= res_fin_r;
            out_miss_r  <= res_miss_r;
            out_full_r  <= res_full_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.running_slot    = out_run_r;
  assign out_ch.job_finished    = out_fin_r;
  assign out_ch.deadline_missed = out_miss_r;
  assign out_ch.table_full      = out_full_r;

endmodule
`default_nettype wire

// ----- hw/rtl/edf_cell.sv -----
// edf_cell: one task slot; holds the slot state and one stage of the search chain
// depends on edf_pkg
`default_nettype none
module edf_cell
  import edf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [SLOT_W-1:0] slot_id,
  input  wire cell_ctrl_t        ctrl,
  input  wire token_t            tok_in,
  output token_t                 tok_out,
  output logic                   used,
  output logic                   dropped,
  output logic                   finished
);

  logic        used_r, ready_r;
  logic [15:0] period_r, rel_dl_r, cap_r, ticks_r;
  logic [31:0] next_rel_r, abs_dl_r;
  token_t      tok_r;
  logic        dropped_r, fin_r;

  logic        me;
  logic [31:0] key;
  logic [15:0] ticks_inc;
  logic        drop_hit;

  assign me        = (ctrl.sel == slot_id);
  assign key       = abs_dl_r - ctrl.cur_time;
  assign ticks_inc = ticks_r + 16'd1;
  assign drop_hit  = used_r & ready_r & reached(ctrl.cur_time, abs_dl_r);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_ADD: begin
        if (me) begin
          period_r   <= ctrl.period;
          rel_dl_r   <= ctrl.rel_dl;
          cap_r      <= ctrl.cap;
          next_rel_r <= ctrl.cur_time;
          abs_dl_r   <= ctrl.cur_time + {16'd0, ctrl.rel_dl};
          ticks_r    <= '0;
        end
      end
      OP_REL: begin
        if (used_r && !ready_r && reached(ctrl.cur_time, next_rel_r)) begin
          ticks_r  <= '0;
          abs_dl_r <= next_rel_r + {16'd0, rel_dl_r};
        end
      end
      OP_DROP: begin
        dropped_r <= drop_hit;
        if (drop_hit) begin
          ticks_r    <= '0;
          next_rel_r <= next_rel_r + {16'd0, period_r};
        end
      end
      OP_SEARCH: begin
        if (used_r && ready_r && (!tok_in.found || key < tok_in.key)) begin
          tok_r <= '{found: 1'b1, key: key, idx: slot_id};
        end else begin
          tok_r <= tok_in;
        end
      end
      OP_RUN: begin
        fin_r <= me && (ticks_inc >= cap_r);
        if (me) begin
          if (ticks_inc >= cap_r) begin
            ticks_r    <= '0;
            next_rel_r <= next_rel_r + {16'd0, period_r};
          end else begin
            ticks_r <= ticks_inc;
          end
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= 1'b0;
      ready_r <= 1'b0;
    end else begin
      case (ctrl.op)
        OP_ADD: if (me) begin
          used_r  <= 1'b1;
          ready_r <= 1'b1;
        end
        OP_REL: if (used_r && !ready_r && reached(ctrl.cur_time, next_rel_r)) begin
          ready_r <= 1'b1;
        end
        OP_DROP: if (drop_hit) begin
          ready_r <= 1'b0;
        end
        OP_RUN: if (me && ticks_inc >= cap_r) begin
          ready_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign tok_out  = tok_r;
  assign used     = used_r;
  assign dropped  = dropped_r;
  assign finished = fin_r;

endmodule
`default_nettype wire

// ----- test/edf_tick_scheduler_unit_test.sv -----
// edf_tick_scheduler_unit_test: self-checking bench for the edf tick scheduler
// depends on edf_pkg, edf_in_if / edf_out_if and edf_tick_scheduler_unit
`default_nettype none
module edf_tick_scheduler_unit_test
  import edf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit ACT_TICK = 1'b0;
  localparam bit ACT_ADD  = 1'b1;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [3:0] slot;
    logic       fin;
    logic       miss;
    logic       full;
  } sched_result_t;

  logic clk;
  logic rst_n;
  edf_in_if  in_ch ();
  edf_out_if out_ch ();

  edf_tick_scheduler_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // predictor state, mirrors the scheduler's slot table
  bit          sl_used [SLOT_COUNT];
  logic [15:0] sl_period [SLOT_COUNT];
  logic [15:0] sl_rel_dl [SLOT_COUNT];
  logic [15:0] sl_cap [SLOT_COUNT];
  logic [31:0] sl_release [SLOT_COUNT];
  logic [31:0] sl_abs_dl [SLOT_COUNT];
  logic [15:0] sl_ran [SLOT_COUNT];
  bit          sl_ready [SLOT_COUNT];
  logic [31:0] sched_time;

  sched_result_t pending_results[$];
  int  error_count;
  int  cycle_count;
  int  send_idle_pct;
  int  recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // free-running watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic bit time_reached(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return ~d[31];
  endfunction

  // job is over, either completed or dropped; next release moves one period on
  function automatic void retire_job(int s);
    sl_ready[s] = 1'b0;
    sl_ran[s] = '0;
    sl_release[s] = sl_release[s] + {16'h0, sl_period[s]};
  endfunction

  // predicts one result transaction for one input item
  function automatic sched_result_t schedule_step(bit act, logic [15:0] per,
                                                  logic [15:0] dl, logic [15:0] cap);
    sched_result_t r;
    int best;
    logic [31:0] best_key;
    logic [31:0] key;
    int free_slot;
    r = '{slot: 4'(SLOT_COUNT), fin: 1'b0, miss: 1'b0, full: 1'b0};
    best = -1;
    best_key = '0;
    free_slot = -1;
    if (act == ACT_ADD) begin
      for (int s = 0; s < SLOT_COUNT; s++)
        if (!sl_used[s] && free_slot < 0) free_slot = s;
      if (free_slot < 0) begin
        r.full = 1'b1;
      end else begin
        sl_used[free_slot] = 1'b1;
        sl_period[free_slot] = per;
        sl_rel_dl[free_slot] = dl;
        sl_cap[free_slot] = cap;
        sl_release[free_slot] = sched_time;
        sl_abs_dl[free_slot] = sched_time + {16'h0, dl};
        sl_ran[free_slot] = '0;
        sl_ready[free_slot] = 1'b1;
      end
    end else begin
      // release pending jobs
      for (int s = 0; s < SLOT_COUNT; s++)
        if (sl_used[s] && !sl_ready[s] && time_reached(sched_time, sl_release[s])) begin
          sl_ready[s] = 1'b1;
          sl_ran[s] = '0;
          sl_abs_dl[s] = sl_release[s] + {16'h0, sl_rel_dl[s]};
        end
      // drop jobs at their deadline
      for (int s = 0; s < SLOT_COUNT; s++)
        if (sl_used[s] && sl_ready[s] && time_reached(sched_time, sl_abs_dl[s])) begin
          retire_job(s);
          r.miss = 1'b1;
        end
      // earliest deadline, lowest slot on a tie
      for (int s = 0; s < SLOT_COUNT; s++)
        if (sl_used[s] && sl_ready[s]) begin
          key = sl_abs_dl[s] - sched_time;
          if (best < 0 || key < best_key) begin
            best = s;
            best_key = key;
          end
        end
      if (best >= 0) begin
        r.slot = 4'(best);
        sl_ran[best] = sl_ran[best] + 16'd1;
        if (sl_ran[best] >= sl_cap[best]) begin
          retire_job(best);
          r.fin = 1'b1;
        end
      end
      sched_time = sched_time + 32'd1;
    end
    return r;
  endfunction

  // sends one transaction; the expectation is queued at acceptance
  // valid stays up after acceptance until the next idle cycle or drain
  task automatic send_item(bit act, logic [15:0] per, logic [15:0] dl, logic [15:0] cap);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.task_period <= per;
    in_ch.task_deadline <= dl;
    in_ch.task_capacity <= cap;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(schedule_step(act, per, dl, cap));
    @(negedge clk);
  endtask

  task automatic send_tick();
    send_item(ACT_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // receiver: stalls at random and checks each result transaction
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    sched_result_t got;
    sched_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.running_slot, out_ch.job_finished, out_ch.deadline_missed,
              out_ch.table_full};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result slot=%0d fin=%b miss=%b full=%b", $realtime,
                 got.slot, got.fin, got.miss, got.full);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected slot=%0d fin=%b miss=%b full=%b, got slot=%0d fin=%b miss=%b full=%b",
                   $realtime, want.slot, want.fin, want.miss, want.full,
                   got.slot, got.fin, got.miss, got.full);
          error_count++;
        end
      end
    end
  end

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // full table, zero capacity, zero deadline, zero period, extreme fields
  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_tick();
    send_item(ACT_ADD, 16'd5, 16'd3, 16'd0);
    send_item(ACT_ADD, 16'd0, 16'd0, 16'd1);
    send_item(ACT_ADD, 16'd0, 16'd4, 16'd2);
    send_item(ACT_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(ACT_ADD, 16'd4, 16'd4, 16'd2);
    repeat (6) send_tick();
    send_item(ACT_ADD, 16'd7, 16'd2, 16'd3);
    send_item(ACT_ADD, 16'd3, 16'd3, 16'd1);
    send_item(ACT_ADD, 16'd1, 16'd1, 16'd1);
    send_item(ACT_ADD, 16'h5555, 16'hAAAA, 16'h5555);
    send_item(ACT_ADD, 16'hAAAA, 16'h5555, 16'hAAAA);
    repeat (8) send_tick();
    drain();
  endtask

  // random ticks with occasional adds, at the given idle and stall percentages, on the already full table
  task automatic test_random_ticks(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) begin
      if ($urandom_range(19) == 0)
        send_item(ACT_ADD, 16'($urandom), 16'($urandom), 16'($urandom));
      else
        send_tick();
    end
    drain();
  endtask

  initial begin
    cycle_count = 0;
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sched_time = '0;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      sl_used[s] = 1'b0;
      sl_ready[s] = 1'b0;
    end
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_TICK;
    in_ch.task_period = '0;
    in_ch.task_deadline = '0;
    in_ch.task_capacity = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random_ticks(110, 0, 0);
    test_random_ticks(110, 46, 0);
    test_random_ticks(110, 0, 46);
    test_random_ticks(110, 28, 28);
    repeat (40) @(negedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
